FILE: design/s88fps_pkg.sv
`timescale 1ns / 1ps

package s88fps_pkg;

  localparam int MODULES = 4;
  localparam int SENSORS = MODULES * 16;
  localparam int SIDX_W  = $clog2(SENSORS);
  localparam int SCNT_W  = $clog2(SENSORS + 1);
  localparam int MOD_W   = (MODULES > 1) ? $clog2(MODULES) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_COUNT = 2'd2;

  localparam logic [7:0] HOLD_RESET   = 8'd10;
  localparam logic [2:0] MODCNT_RESET = 3'd4;

  localparam logic [7:0] CH_INFO = 8'h69;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_SENSOR = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_SKIP  = 7'b0000010,
    PH_COUNT = 7'b0000100,
    PH_MODNR = 7'b0001000,
    PH_HIGH  = 7'b0010000,
    PH_LOW   = 7'b0100000,
    PH_CR    = 7'b1000000
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_UPD     = 5'b00010,
    ST_SCAN_RD = 5'b00100,
    ST_SCAN_EV = 5'b01000,
    ST_FLUSH   = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic upd_step;
    logic scan_ev;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_upd;
    logic need_scan;
    logic need_err;
    logic stall;
    logic upd_done;
    logic scan_done;
  } dp_stat_t;

endpackage

FILE: design/s88fps_ctrl.sv
`timescale 1ns / 1ps

module s88fps_ctrl import s88fps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && (state == ST_IDLE);
    cmd.upd_step = (state == ST_UPD);
    cmd.scan_ev  = (state == ST_SCAN_EV);
    cmd.flush    = (state == ST_FLUSH);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (stat.need_upd) state_next = ST_UPD;
          else if (stat.need_scan) state_next = ST_SCAN_RD;
          else if (stat.need_err) state_next = ST_FLUSH;
        end
      end
      ST_UPD: begin
        if (!stat.stall && stat.upd_done) state_next = ST_FLUSH;
      end
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!stat.stall) state_next = stat.scan_done ? ST_FLUSH : ST_SCAN_RD;
      end
      ST_FLUSH: begin
        if (!stat.stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: design/s88fps_datapath.sv
`timescale 1ns / 1ps

module s88fps_datapath import s88fps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  op,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  event_kind,
  output logic [6:0]            sensor_addr,
  output logic                  sensor_state,
  output logic                  last
);

  // configuration
  logic       smooth;
  logic [7:0] hold_ticks;
  logic [2:0] mod_count;

  // parser
  phase_t     phase, phase_next;
  logic [7:0] modules_left;
  logic [7:0] module_number;
  logic [7:0] high_bits;
  logic       mod_valid;

  // sensor state
  logic [15:0]       raw_bits [MODULES];
  logic [SENSORS-1:0] rep;
  logic [SENSORS-1:0] pend;
  logic [15:0]       tick_now;
  logic [15:0]       stamp_mem [SENSORS];
  logic [15:0]       stamp_q;
  logic              stamp_we;

  // module update walk
  logic [MOD_W-1:0]  mod_sel;
  logic [15:0]       old_bits;
  logic [15:0]       new_bits;
  logic [3:0]        upd_k;
  logic [3:0]        bitpos;
  logic [SIDX_W-1:0] upd_idx;
  logic              upd_level;
  logic              upd_chg;
  logic              upd_hit;

  // tick scan
  logic [SIDX_W-1:0] scan_idx;
  logic [SCNT_W-1:0] scan_lim;
  logic [15:0]       age;
  logic              scan_hit;

  // result staging
  logic       hold_valid;
  logic       hold_kind;
  logic [6:0] hold_addr;
  logic       hold_state;
  logic       res_hit;
  logic [6:0] res_addr;
  logic       res_level;
  logic       out_free;
  logic       stall;
  logic       go;
  logic       push_mid;
  logic       push_end;
  logic       acc_byte;
  logic       acc_tick;

  assign acc_byte  = cmd.accept && (op == OP_BYTE);
  assign acc_tick  = cmd.accept && (op == OP_TICK);
  assign mod_valid = (module_number != 8'd0) && (32'(module_number) <= MODULES);

  // update step: even steps take high bit j, odd steps low bit j
  assign bitpos    = {~upd_k[0], upd_k[3:1]};
  assign upd_idx   = SIDX_W'({mod_sel, bitpos});
  assign upd_level = new_bits[bitpos];
  assign upd_chg   = new_bits[bitpos] != old_bits[bitpos];
  assign upd_hit   = upd_chg && (!smooth || (upd_level && !rep[upd_idx]));

  always_comb begin
    if (32'(mod_count) < MODULES) scan_lim = SCNT_W'(mod_count) << 4;
    else scan_lim = SCNT_W'(SENSORS);
  end

  assign age      = tick_now - stamp_q;
  assign scan_hit = rep[scan_idx] && pend[scan_idx] && (age >= {8'd0, hold_ticks});

  assign res_hit   = (cmd.upd_step && upd_hit) || (cmd.scan_ev && scan_hit);
  assign res_addr  = cmd.upd_step ? (7'(upd_idx) + 7'd1) : (7'(scan_idx) + 7'd1);
  assign res_level = cmd.upd_step ? upd_level : 1'b0;
  assign out_free  = !out_valid || out_ready;
  assign stall     = (res_hit || cmd.flush) && hold_valid && !out_free;
  assign go        = !stall;
  assign push_mid  = res_hit && hold_valid && out_free;
  assign push_end  = cmd.flush && hold_valid && out_free;
  assign stamp_we  = cmd.upd_step && go && upd_chg && smooth && !upd_level && rep[upd_idx];

  always_comb begin
    stat           = '0;
    stat.need_upd  = (op == OP_BYTE) && (phase == PH_LOW) && mod_valid;
    stat.need_scan = (op == OP_TICK) && smooth && (mod_count != 3'd0);
    stat.need_err  = (op == OP_BYTE) && (phase == PH_CR) && (rx_byte != CH_CR);
    stat.stall     = stall;
    stat.upd_done  = (upd_k == 4'd15);
    stat.scan_done = (SCNT_W'(scan_idx) + SCNT_W'(1)) == scan_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth     <= 1'b0;
      hold_ticks <= HOLD_RESET;
      mod_count  <= MODCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMOOTH:    smooth     <= cfg_data[0];
        CFG_HOLD:      hold_ticks <= cfg_data;
        CFG_MOD_COUNT: mod_count  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == CH_INFO) phase_next = PH_COUNT;
        else if (rx_byte != CH_CR) phase_next = PH_SKIP;
      end
      PH_SKIP:  if (rx_byte == CH_CR) phase_next = PH_IDLE;
      PH_COUNT: phase_next = (rx_byte != 8'd0) ? PH_MODNR : PH_CR;
      PH_MODNR: phase_next = PH_HIGH;
      PH_HIGH:  phase_next = PH_LOW;
      PH_LOW:   phase_next = (modules_left != 8'd1) ? PH_MODNR : PH_CR;
      PH_CR:    phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      modules_left  <= 8'd0;
      module_number <= 8'd0;
      high_bits     <= 8'd0;
      tick_now      <= 16'd0;
      for (int i = 0; i < MODULES; i++) raw_bits[i] <= 16'd0;
    end else begin
      if (acc_tick) tick_now <= tick_now + 16'd1;
      if (acc_byte) begin
        phase <= phase_next;
        case (phase)
          PH_COUNT: modules_left  <= rx_byte;
          PH_MODNR: module_number <= rx_byte;
          PH_HIGH:  high_bits     <= rx_byte;
          PH_LOW: begin
            modules_left <= modules_left - 8'd1;
            if (mod_valid) raw_bits[MOD_W'(module_number - 8'd1)] <= {high_bits, rx_byte};
          end
          default: ;
        endcase
      end
    end
  end

  // snapshot of the module's old and new bits for the update walk
  always_ff @(posedge clk) begin
    if (acc_byte && (phase == PH_LOW) && mod_valid) begin
      mod_sel  <= MOD_W'(module_number - 8'd1);
      old_bits <= raw_bits[MOD_W'(module_number - 8'd1)];
      new_bits <= {high_bits, rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_k    <= 4'd0;
      scan_idx <= '0;
    end else if (cmd.accept) begin
      upd_k    <= 4'd0;
      scan_idx <= '0;
    end else begin
      if (cmd.upd_step && go) upd_k <= upd_k + 4'd1;
      if (cmd.scan_ev && go) scan_idx <= scan_idx + SIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep  <= '0;
      pend <= '0;
    end else if (cmd.upd_step && go && upd_chg) begin
      if (!smooth) begin
        rep[upd_idx]  <= upd_level;
        pend[upd_idx] <= 1'b0;
      end else if (upd_level) begin
        rep[upd_idx]  <= 1'b1;
        pend[upd_idx] <= 1'b0;
      end else if (rep[upd_idx]) begin
        pend[upd_idx] <= 1'b1;
      end
    end else if (cmd.scan_ev && go && scan_hit) begin
      rep[scan_idx]  <= 1'b0;
      pend[scan_idx] <= 1'b0;
    end
  end

  // fall time stamps, used only while a fall is pending
  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[upd_idx] <= tick_now;
    stamp_q <= stamp_mem[scan_idx];
  end

  // one-deep hold: a result leaves only once the next one (or the end) is known
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (acc_byte && stat.need_err) begin
      hold_valid <= 1'b1;
      hold_kind  <= KIND_FRAME;
      hold_addr  <= 7'd0;
      hold_state <= 1'b0;
    end else if (res_hit && go) begin
      hold_valid <= 1'b1;
      hold_kind  <= KIND_SENSOR;
      hold_addr  <= res_addr;
      hold_state <= res_level;
    end else if (push_end) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid    <= 1'b1;
      event_kind   <= hold_kind;
      sensor_addr  <= hold_addr;
      sensor_state <= hold_state;
      last         <= push_end;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/s88_feedback_parser_smoother.sv
`timescale 1ns / 1ps

// Feedback report parser with low-level smoothing.
// Input channel (in_valid/in_ready): one beat is a received link byte (op = 0)
// or one time tick (op = 1). Output channel (out_valid/out_ready): one beat is
// a sensor change or a framing error; last marks the final beat of an input.
// Config port: cfg_we with cfg_index/cfg_data, taken on the same edge.
// Sequence, one input beat at a time:
//   byte or plain tick, no results : accept only, next beat accepted right after
//   low byte of a valid module : accept, 16 bit steps, flush
//   tick with smoothing on     : accept, then for each of N = min(module_count, 4)*16
//                                sensors a time-stamp RAM read and a test, then flush;
//                                accept only when module_count is 0
//   missing CR                 : accept, flush
// A result moves to the output register once it is known to be last or not; the
// block holds one result in a staging register and one in the output register.
// When the receiver stalls, the bit walk or scan stops on the next result
// until the output register frees up. An input beat is taken while the final
// result still waits in the output register.
// Reset (rst, synchronous) clears parser, sensor levels, pending falls, the
// tick counter and restores config defaults; time stamps need no clearing.

module s88_feedback_parser_smoother import s88fps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  event_kind,
  output logic [6:0]            sensor_addr,
  output logic                  sensor_state,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept, bit walk, scan, flush
  s88fps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // parser, sensor state, stamp RAM, staging and output registers
  s88fps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .rx_byte      (rx_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .sensor_addr  (sensor_addr),
    .sensor_state (sensor_state),
    .last         (last)
  );

endmodule

FILE: design/s88fps_checker.sv
`timescale 1ns / 1ps

module s88fps_checker import s88fps_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       event_kind,
  input logic [6:0] sensor_addr,
  input logic       sensor_state,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sensor_addr) &&
      $stable(sensor_state) && $stable(event_kind) && $stable(last))
    else $error("output beat changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_FRAME) |-> (sensor_addr == 7'd0) &&
      !sensor_state && last)
    else $error("framing error beat malformed");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_SENSOR) |-> (sensor_addr != 7'd0) &&
      (32'(sensor_addr) <= SENSORS))
    else $error("sensor address out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind s88_feedback_parser_smoother s88fps_checker u_chk (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Feedback parser / smoother testbench.
// Link bytes and ticks go in through a queue of pending beats. Each accepted
// beat runs through the parse/smoothing predictor below, which pushes the sensor
// and framing events it should cause. The monitor pops one event per output beat
// and compares it field by field.
module tb;
  import s88fps_pkg::*;

  localparam int SETTLE_CYCLES = 200;   // longest silent job: a full 64-sensor scan
  localparam int LONG_HOLD     = 400;   // receiver back-pressure burst
  localparam int MAX_ERR_LINES = 100;

  typedef struct packed {
    logic       kind;
    logic [6:0] addr;
    logic       level;
    logic       last;
  } sensor_event_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } link_beat_t;

  // DUT ports; everything driven starts at a known value
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic                  op           = OP_BYTE;
  logic [7:0]            rx_byte      = 8'h00;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  event_kind;
  logic [6:0]            sensor_addr;
  logic                  sensor_state;
  logic                  last;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_SMOOTH;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Predictor state
  phase_t      rx_phase;
  logic [7:0]  mods_left;
  logic [7:0]  cur_module;
  logic [7:0]  hi_latch;
  logic [15:0] mod_bits     [MODULES];
  logic        shown_level  [SENSORS];
  logic        fall_pending [SENSORS];
  logic [15:0] fall_tick    [SENSORS];
  logic [15:0] tick_ctr;
  logic        smooth_on;
  logic [7:0]  hold_ticks;
  logic [2:0]  scan_mods;

  sensor_event_t beat_events[$];   // events of the beat being predicted
  sensor_event_t due_events[$];    // events still owed by the DUT
  link_beat_t    tx_items[$];      // beats waiting for the driver
  link_beat_t    next_beat;
  logic [15:0]   gen_bits [MODULES];  // last bits sent per module, to bias stimulus

  int beats_queued  = 0;
  int beats_in      = 0;
  int err_cnt       = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  bit beat_taken    = 1'b0;

  s88_feedback_parser_smoother dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .sensor_addr  (sensor_addr),
    .sensor_state (sensor_state),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic add_event(input logic kind, input int addr, input logic lvl);
    sensor_event_t e;
    e.kind  = kind;
    e.addr  = addr[6:0];
    e.level = lvl;
    e.last  = 1'b0;
    beat_events.push_back(e);
  endtask

  // One raw bit change. With smoothing, rises go out at once and falls wait.
  task automatic sensor_edge(input int idx, input logic lvl);
    if (!smooth_on) begin
      shown_level[idx]  = lvl;
      fall_pending[idx] = 1'b0;
      add_event(KIND_SENSOR, idx + 1, lvl);
    end else if (lvl) begin
      fall_pending[idx] = 1'b0;        // a rise cancels a pending fall
      if (!shown_level[idx]) begin
        shown_level[idx] = 1'b1;
        add_event(KIND_SENSOR, idx + 1, 1'b1);
      end
    end else if (shown_level[idx]) begin
      fall_pending[idx] = 1'b1;
      fall_tick[idx]    = tick_ctr;
    end
  endtask

  // Low byte closes a triple: walk bits 0..7, high-byte bit before low-byte bit.
  task automatic merge_module(input logic [7:0] lo);
    logic [15:0] old;
    int          base;
    if (cur_module < 1 || cur_module > MODULES) return;  // invalid module: dropped
    old  = mod_bits[cur_module - 1];
    base = (cur_module - 1) * 16;
    for (int j = 0; j < 8; j++) begin
      if (hi_latch[j] != old[8 + j]) sensor_edge(base + 8 + j, hi_latch[j]);
      if (lo[j] != old[j]) sensor_edge(base + j, lo[j]);
    end
    mod_bits[cur_module - 1] = {hi_latch, lo};
  endtask

  task automatic scan_falls();
    int          lim;
    logic [15:0] age;
    lim = ((scan_mods < MODULES) ? int'(scan_mods) : MODULES) * 16;
    for (int i = 0; i < lim; i++) begin
      age = tick_ctr - fall_tick[i];   // wraps mod 2^16
      if (shown_level[i] && fall_pending[i] && age >= {8'h00, hold_ticks}) begin
        shown_level[i]  = 1'b0;
        fall_pending[i] = 1'b0;
        add_event(KIND_SENSOR, i + 1, 1'b0);
      end
    end
  endtask

  task automatic parse_link_beat(input logic op_i, input logic [7:0] b);
    sensor_event_t tail;
    beat_events.delete();
    if (op_i == OP_TICK) begin
      tick_ctr = tick_ctr + 16'd1;     // advance before the scan
      if (smooth_on) scan_falls();
    end else begin
      case (rx_phase)
        PH_IDLE: begin
          if (b == CH_INFO) rx_phase = PH_COUNT;
          else if (b != CH_CR) rx_phase = PH_SKIP;  // lone CR keeps us idle
        end
        PH_SKIP: begin
          if (b == CH_CR) rx_phase = PH_IDLE;
        end
        PH_COUNT: begin
          mods_left = b;
          rx_phase  = (b != 8'd0) ? PH_MODNR : PH_CR;
        end
        PH_MODNR: begin
          cur_module = b;
          rx_phase   = PH_HIGH;
        end
        PH_HIGH: begin
          hi_latch = b;
          rx_phase = PH_LOW;
        end
        PH_LOW: begin
          merge_module(b);
          mods_left = mods_left - 8'd1;
          rx_phase  = (mods_left != 8'd0) ? PH_MODNR : PH_CR;
        end
        PH_CR: begin
          if (b != CH_CR) add_event(KIND_FRAME, 0, 1'b0);  // missing CR, byte eaten
          rx_phase = PH_IDLE;
        end
        default: rx_phase = PH_IDLE;
      endcase
    end
    if (beat_events.size() != 0) begin
      tail      = beat_events.pop_back();
      tail.last = 1'b1;
      beat_events.push_back(tail);
    end
    foreach (beat_events[k]) due_events.push_back(beat_events[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    // print is capped so a dead DUT cannot flood the log; all are counted
    if (err_cnt < MAX_ERR_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_event();
    sensor_event_t want;
    if (due_events.size() == 0) begin
      report($sformatf("event with none due: kind=%0b addr=%0d level=%0b",
                       event_kind, sensor_addr, sensor_state));
      return;
    end
    want = due_events.pop_front();
    if (event_kind !== want.kind)
      report($sformatf("event_kind %0b, want %0b (addr %0d)", event_kind, want.kind, want.addr));
    if (sensor_addr !== want.addr)
      report($sformatf("sensor_addr %0d, want %0d", sensor_addr, want.addr));
    if (sensor_state !== want.level)
      report($sformatf("sensor_state %0b, want %0b (addr %0d)",
                       sensor_state, want.level, want.addr));
    if (last !== want.last)
      report($sformatf("last %0b, want %0b (addr %0d)", last, want.last, want.addr));
  endtask

  // Monitor: sample both channels at the rising edge. The output beat is
  // checked before the input beat is predicted; an input taken on this edge
  // cannot have produced the output on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_event();
      if (in_valid && in_ready) begin
        parse_link_beat(op, rx_byte);
        beats_in++;
        beat_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = tx_items.pop_front();
        in_valid <= 1'b1;
        op       <= next_beat.op;
        rx_byte  <= next_beat.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off burst on request
  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      hold_left  = LONG_HOLD;
      holds_done = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    link_beat_t t;
    t.op   = OP_BYTE;
    t.data = b;
    tx_items.push_back(t);
    beats_queued++;
  endtask

  task automatic push_tick();
    link_beat_t t;
    t.op   = OP_TICK;
    t.data = 8'($urandom_range(255));   // ignored by the block
    tx_items.push_back(t);
    beats_queued++;
  endtask

  task automatic push_triple(input logic [7:0] m, input logic [15:0] v);
    push_byte(m);
    push_byte(v[15:8]);
    push_byte(v[7:0]);
    if (m >= 1 && m <= MODULES) gen_bits[m - 1] = v;
  endtask

  function automatic logic [7:0] rand_byte_except(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == x);
    return b;
  endfunction

  // Feedback report with random content. Broken ones either drop the last
  // triple or put a wrong byte where CR belongs.
  task automatic gen_report(input bit close_ok);
    int          cnt;
    int          nsent;
    int          m;
    logic [15:0] v;
    cnt = $urandom_range(1, MODULES);
    if ($urandom_range(9) == 0) cnt = 0;
    else if ($urandom_range(14) == 0) cnt = $urandom_range(MODULES + 1, 7);
    nsent = (!close_ok && cnt != 0 && $urandom_range(1)) ? cnt - 1 : cnt;
    push_byte(CH_INFO);
    push_byte(8'(cnt));
    repeat (nsent) begin
      if ($urandom_range(9) == 0) begin
        m = $urandom_range(1) ? 0 : $urandom_range(MODULES + 1, 255);
        v = 16'($urandom);
      end else begin
        m = $urandom_range(1, MODULES);
        if ($urandom_range(3) == 0) begin
          v = 16'($urandom);
        end else begin
          // flip one or two bits against what was sent last (a repeated pick flips back)
          v = gen_bits[m - 1] ^ (16'd1 << $urandom_range(15));
          if ($urandom_range(1)) v = v ^ (16'd1 << $urandom_range(15));
        end
      end
      push_triple(8'(m), v);
    end
    if (close_ok || nsent != cnt) push_byte(CH_CR);
    else push_byte(rand_byte_except(CH_CR));
  endtask

  task automatic gen_traffic(input int n);
    int goal;
    int r;
    goal = beats_queued + n;
    while (beats_queued < goal) begin
      r = $urandom_range(99);
      if (r < 65) begin
        gen_report(1'b1);
        repeat ($urandom_range(0, 3)) push_tick();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 8)) push_tick();
      end else if (r < 85) begin
        gen_report(1'b0);
      end else if (r < 93) begin
        // foreign message, skipped up to its CR
        push_byte(rand_byte_except(CH_INFO));
        repeat ($urandom_range(0, 4)) push_byte(rand_byte_except(CH_CR));
        push_byte(CH_CR);
      end else begin
        push_byte(rand_byte_except(CH_INFO));   // stray byte
      end
    end
  endtask

  // Registers only change while nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SMOOTH:    smooth_on  = val[0];
      CFG_HOLD:      hold_ticks = val;
      CFG_MOD_COUNT: scan_mods  = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic s, input logic [7:0] h, input logic [2:0] m);
    write_reg(CFG_SMOOTH, {7'b0, s});
    write_reg(CFG_HOLD, h);
    write_reg(CFG_MOD_COUNT, {5'b0, m});
  endtask

  task automatic wait_drain();
    while (beats_in != beats_queued || due_events.size() != 0) @(negedge clk);
  endtask

  // A tick scan or a bit walk with no results can still be busy after the
  // last event; give it time before touching registers.
  task automatic settle_phase();
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rx_phase   = PH_IDLE;
    mods_left  = '0;
    cur_module = '0;
    hi_latch   = '0;
    tick_ctr   = '0;
    smooth_on  = 1'b0;
    hold_ticks = HOLD_RESET;
    scan_mods  = MODCNT_RESET;
    for (int i = 0; i < MODULES; i++) begin
      mod_bits[i] = '0;
      gen_bits[i] = '0;
    end
    for (int i = 0; i < SENSORS; i++) begin
      shown_level[i]  = 1'b0;
      fall_pending[i] = 1'b0;
      fall_tick[i]    = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 49;

    // Directed, plain mode: every change reported at once
    set_regs(1'b0, 8'd10, 3'd4);
    push_byte(CH_CR);                                   // lone CR while idle
    push_byte(CH_INFO); push_byte(8'h00); push_byte(CH_CR);  // zero modules
    push_byte(CH_INFO); push_byte(8'd2);
    push_triple(8'd1, 16'hFFFF);                        // all 16 rise, each high bit before its low bit
    push_triple(8'd0, 16'h1234);                        // module 0 is dropped
    push_byte(8'h78);                                   // wrong byte where CR is due
    push_byte(CH_INFO); push_byte(8'd1);
    push_triple(8'd255, 16'hABCD);                      // module out of range
    push_byte(CH_CR);
    push_byte(8'h7A); push_byte(CH_INFO); push_byte(CH_CR);  // foreign message
    push_tick();                                        // tick without smoothing
    settle_phase();

    // Directed, smoothing with zero hold time
    set_regs(1'b1, 8'd0, 3'd4);
    push_byte(CH_INFO); push_byte(8'd1);
    push_triple(8'd1, 16'h0FF0);                        // eight falls go pending
    push_byte(CH_CR);
    push_byte(CH_INFO); push_byte(8'd1);
    push_triple(8'd1, 16'h8FF0);                        // rise cancels one pending fall
    push_byte(CH_CR);
    push_tick();                                        // remaining seven come out
    settle_phase();

    // Random traffic, smoothing on, full scan range; the sender pauses halfway
    // until every due event is out
    set_regs(1'b1, 8'd3, 3'd4);
    gen_traffic(50);
    wait_drain();
    gen_traffic(50);
    settle_phase();

    send_idle_pct = 49;
    recv_idle_pct = 29;

    // Longest hold time and an empty scan range: falls pile up as pending
    set_regs(1'b1, 8'd255, 3'd0);
    gen_traffic(30);
    settle_phase();

    // Plain mode; receiver blocks for a long burst while beats keep coming
    set_regs(1'b0, 8'd1, 3'd2);
    gen_traffic(50);
    hold_reqs++;
    settle_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Partial scan range: lows above module 2 keep waiting
    set_regs(1'b1, 8'd1, 3'd2);
    gen_traffic(50);
    settle_phase();

    // Count above the module total clamps the scan
    set_regs(1'b1, 8'd5, 3'd7);
    gen_traffic(50);
    settle_phase();

    set_regs(1'b1, 8'd2, 3'd3);
    gen_traffic(30);
    settle_phase();

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Slowest legal run ends well before this watchdog fires
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
